// ----- hdl/fesg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fesg_pkg;

  localparam int MAX_RADIUS = 31;
  localparam int FRAC_BITS  = 6;
  localparam int FRAC_HALF  = 32;
  localparam int OUT_CAP    = 64;
  localparam int GUARD_LAST = 8191;

  localparam logic [1:0] CFG_CLIP_LEFT   = 2'd0;
  localparam logic [1:0] CFG_CLIP_TOP    = 2'd1;
  localparam logic [1:0] CFG_CLIP_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_CLIP_HEIGHT = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NEG     = 2'd1;
  localparam logic [1:0] ST_TOO_BIG = 2'd2;

  // divider operand select
  localparam logic [1:0] DS_J = 2'd0;
  localparam logic [1:0] DS_K = 2'd1;
  localparam logic [1:0] DS_X = 2'd2;
  localparam logic [1:0] DS_Y = 2'd3;

  // span source select
  localparam logic [2:0] ES_ZERO = 3'd0;
  localparam logic [2:0] ES_R1P  = 3'd1;
  localparam logic [2:0] ES_R1M  = 3'd2;
  localparam logic [2:0] ES_R2P  = 3'd3;
  localparam logic [2:0] ES_R2M  = 3'd4;

  typedef struct packed {
    logic       load;
    logic       init_walk;
    logic       latch_hi;
    logic       div_start;
    logic [1:0] div_sel;
    logic       emit;
    logic [2:0] emit_sel;
    logic       set_la;
    logic       set_lb;
    logic       finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pre_done;
    logic zero_span;
    logic box_miss;
    logic div_done;
    logic cond1;
    logic cond2;
    logic r1_pos;
    logic r2_pos;
    logic loop_more;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/fesg_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fesg_div import fesg_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [15:0] dividend_i,
  input  wire logic        [4:0]  divisor_i,
  output logic                    done_o,
  output logic signed [15:0]      quot_o
);

  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [4:0]  rem_q, rem_d;
  logic [15:0] num_q, num_d;
  logic        neg_q, neg_d;
  logic [4:0]  dvs_q, dvs_d;
  logic        done_q, done_d;
  logic [5:0]  trial;

  assign trial = {rem_q, num_q[15]};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    neg_d  = neg_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd16;
      rem_d  = '0;
      neg_d  = dividend_i[15];
      num_d  = dividend_i[15] ? 16'(-dividend_i) : dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // one restoring step a cycle
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = 5'(trial - {1'b0, dvs_q});
        num_d = {num_q[14:0], 1'b1};
      end else begin
        rem_d = trial[4:0];
        num_d = {num_q[14:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    neg_q <= neg_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? 16'(-num_q) : num_q;

endmodule

`default_nettype wire

// ----- hdl/fesg_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fesg_ctrl import fesg_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire dp_stat_t stat_i,
  output ctrl_cmd_t     cmd_o,
  output logic          busy_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_HI    = 4'd2;
  localparam logic [3:0] S_DIVJ  = 4'd3;
  localparam logic [3:0] S_WJ    = 4'd4;
  localparam logic [3:0] S_DIVK  = 4'd5;
  localparam logic [3:0] S_WK    = 4'd6;
  localparam logic [3:0] S_R1A   = 4'd7;
  localparam logic [3:0] S_R1B   = 4'd8;
  localparam logic [3:0] S_R2A   = 4'd9;
  localparam logic [3:0] S_R2B   = 4'd10;
  localparam logic [3:0] S_DIVX  = 4'd11;
  localparam logic [3:0] S_WX    = 4'd12;
  localparam logic [3:0] S_DIVY  = 4'd13;
  localparam logic [3:0] S_WY    = 4'd14;
  localparam logic [3:0] S_FIN   = 4'd15;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.pre_done) begin
          state_d = S_FIN;
        end else if (stat_i.zero_span) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = ES_ZERO;
          state_d        = S_FIN;
        end else if (stat_i.box_miss) begin
          state_d = S_FIN;
        end else begin
          cmd_o.init_walk = 1'b1;
          state_d         = S_HI;
        end
      end
      S_HI: begin
        cmd_o.latch_hi = 1'b1;
        state_d        = S_DIVJ;
      end
      S_DIVJ: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DS_J;
        state_d         = S_WJ;
      end
      S_WJ: begin
        cmd_o.div_sel = DS_J;
        if (stat_i.div_done) state_d = S_DIVK;
      end
      S_DIVK: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DS_K;
        state_d         = S_WK;
      end
      S_WK: begin
        cmd_o.div_sel = DS_K;
        if (stat_i.div_done) state_d = S_R1A;
      end
      S_R1A: begin
        state_d = S_R2A;
        if (stat_i.cond1) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = ES_R1P;
          cmd_o.set_la   = 1'b1;
          if (stat_i.r1_pos) state_d = S_R1B;
        end
      end
      S_R1B: begin
        cmd_o.emit     = 1'b1;
        cmd_o.emit_sel = ES_R1M;
        state_d        = S_R2A;
      end
      S_R2A: begin
        state_d = S_DIVX;
        if (stat_i.cond2) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = ES_R2P;
          cmd_o.set_lb   = 1'b1;
          if (stat_i.r2_pos) state_d = S_R2B;
        end
      end
      S_R2B: begin
        cmd_o.emit     = 1'b1;
        cmd_o.emit_sel = ES_R2M;
        state_d        = S_DIVX;
      end
      S_DIVX: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DS_X;
        state_d         = S_WX;
      end
      S_WX: begin
        cmd_o.div_sel = DS_X;
        if (stat_i.div_done) state_d = S_DIVY;
      end
      S_DIVY: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DS_Y;
        state_d         = S_WY;
      end
      S_WY: begin
        cmd_o.div_sel = DS_Y;
        if (stat_i.div_done) state_d = stat_i.loop_more ? S_HI : S_FIN;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ----- hdl/fesg_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fesg_dp import fesg_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ctrl_cmd_t          cmd_i,
  output dp_stat_t                stat_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [14:0]        cfg_data_i,
  input  wire logic signed [15:0] center_x_i,
  input  wire logic signed [15:0] center_y_i,
  input  wire logic signed [15:0] radius_x_i,
  input  wire logic signed [15:0] radius_y_i,
  output logic                    span_strobe_o,
  output logic                    span_valid_o,
  output logic [14:0]             span_x_first_o,
  output logic [14:0]             span_x_last_o,
  output logic [14:0]             span_y_first_o,
  output logic [14:0]             span_y_last_o,
  output logic [1:0]              status_o,
  output logic                    last_span_o
);

  // clip registers
  logic [13:0] clip_left_q, clip_top_q;
  logic [14:0] clip_width_q, clip_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q   <= '0;
      clip_top_q    <= '0;
      clip_width_q  <= 15'd320;
      clip_height_q <= 15'd240;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CLIP_LEFT:   clip_left_q   <= cfg_data_i[13:0];
        CFG_CLIP_TOP:    clip_top_q    <= cfg_data_i[13:0];
        CFG_CLIP_WIDTH:  clip_width_q  <= cfg_data_i;
        CFG_CLIP_HEIGHT: clip_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [15:0] c_l, c_t, c_r, c_b;
  assign c_l = {2'b00, clip_left_q};
  assign c_t = {2'b00, clip_top_q};
  assign c_r = 16'({2'b00, clip_left_q} + {1'b0, clip_width_q} - 16'd1);
  assign c_b = 16'({2'b00, clip_top_q} + {1'b0, clip_height_q} - 16'd1);

  // request registers
  logic signed [15:0] cx_q, cy_q, rx_q, ry_q;
  logic [1:0]         st_q, st_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cx_q <= center_x_i;
      cy_q <= center_y_i;
      rx_q <= radius_x_i;
      ry_q <= radius_y_i;
    end
  end

  logic empty_clip, neg_rad, big_rad, wide;
  logic [4:0] big_r, small_r;

  assign empty_clip = (clip_width_q == '0) || (clip_height_q == '0);
  assign neg_rad    = rx_q[15] || ry_q[15];
  assign big_rad    = (rx_q > 16'(MAX_RADIUS)) || (ry_q > 16'(MAX_RADIUS));
  assign wide       = rx_q > ry_q;
  assign big_r      = wide ? rx_q[4:0] : ry_q[4:0];
  assign small_r    = wide ? ry_q[4:0] : rx_q[4:0];

  always_comb begin
    st_d = st_q;
    if (empty_clip)   st_d = ST_OK;
    else if (neg_rad) st_d = ST_NEG;
    else if (big_rad) st_d = ST_TOO_BIG;
    else              st_d = ST_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_OK;
    end else if (cmd_i.load) begin
      st_q <= ST_OK;
    end else if (!cmd_i.finish) begin
      st_q <= st_d;
    end
  end

  // walk registers
  logic signed [15:0] ix_q, iy_q, h_q, i_q, j_q, k_q, la_q, lb_q;
  logic               lav_q, lbv_q;
  logic [12:0]        guard_q;
  logic signed [15:0] h_n, i_n;
  logic signed [15:0] div_num, quot;
  logic               div_done;
  logic signed [15:0] r1, w1, r2, w2;

  assign h_n = 16'(ix_q + 16'(FRAC_HALF)) >>> FRAC_BITS;
  assign i_n = 16'(iy_q + 16'(FRAC_HALF)) >>> FRAC_BITS;

  always_comb begin
    case (cmd_i.div_sel)
      DS_J:    div_num = 16'(h_q * $signed({11'd0, small_r}));
      DS_K:    div_num = 16'(i_q * $signed({11'd0, small_r}));
      DS_X:    div_num = iy_q;
      default: div_num = ix_q;
    endcase
  end

  fesg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_num),
    .divisor_i  (big_r),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lav_q   <= 1'b0;
      lbv_q   <= 1'b0;
      guard_q <= '0;
    end else if (cmd_i.init_walk) begin
      lav_q   <= 1'b0;
      lbv_q   <= 1'b0;
      guard_q <= '0;
    end else begin
      if (cmd_i.set_la) lav_q <= 1'b1;
      if (cmd_i.set_lb) lbv_q <= 1'b1;
      if (div_done && cmd_i.div_sel == DS_Y) guard_q <= guard_q + 13'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_walk) begin
      ix_q <= '0;
      iy_q <= {5'd0, big_r, 6'd0};
    end
    if (cmd_i.latch_hi) begin
      h_q <= h_n;
      i_q <= i_n;
    end
    if (div_done) begin
      case (cmd_i.div_sel)
        DS_J:    j_q  <= quot;
        DS_K:    k_q  <= quot;
        DS_X:    ix_q <= 16'(ix_q + quot);
        default: iy_q <= 16'(iy_q - quot);
      endcase
    end
    if (cmd_i.set_la) la_q <= r1;
    if (cmd_i.set_lb) lb_q <= r2;
  end

  assign r1 = wide ? k_q : i_q;
  assign w1 = wide ? h_q : j_q;
  assign r2 = wide ? j_q : h_q;
  assign w2 = wide ? i_q : k_q;

  assign stat_o.pre_done  = empty_clip || neg_rad || big_rad;
  assign stat_o.zero_span = (rx_q == '0) || (ry_q == '0);
  assign stat_o.box_miss  = (16'(cx_q + rx_q) < c_l) || (16'(cx_q - rx_q) > c_r) ||
                            (16'(cy_q + ry_q) < c_t) || (16'(cy_q - ry_q) > c_b);
  assign stat_o.div_done  = div_done;
  assign stat_o.cond1     = (!lav_q || la_q != r1) && (!lbv_q || lb_q != r1);
  assign stat_o.cond2     = (!lbv_q || lb_q != r2) && (!lav_q || la_q != r2) && (r1 != r2);
  assign stat_o.r1_pos    = r1 > 16'sd0;
  assign stat_o.r2_pos    = r2 > 16'sd0;
  assign stat_o.loop_more = (i_q > h_q) && (guard_q != 13'(GUARD_LAST));

  // span select, order and clip
  logic signed [15:0] xa, xb, ya, yb, x1, x2, y1, y2, hw, dy;
  logic               in_clip;

  always_comb begin
    hw = w1;
    dy = r1;
    case (cmd_i.emit_sel)
      ES_R1P, ES_R1M: begin
        hw = w1;
        dy = r1;
      end
      ES_R2P, ES_R2M: begin
        hw = w2;
        dy = r2;
      end
      default: ;
    endcase
    xa = 16'(cx_q - hw);
    xb = 16'(cx_q + hw);
    ya = (dy > 16'sd0) ? 16'(cy_q + dy) : cy_q;
    if (cmd_i.emit_sel inside {ES_R1M, ES_R2M}) ya = 16'(cy_q - dy);
    yb = ya;
    if (cmd_i.emit_sel == ES_ZERO) begin
      if (rx_q == '0) begin
        xa = cx_q;
        xb = cx_q;
        ya = 16'(cy_q - ry_q);
        yb = 16'(cy_q + ry_q);
      end else begin
        xa = 16'(cx_q - rx_q);
        xb = 16'(cx_q + rx_q);
        ya = cy_q;
        yb = cy_q;
      end
    end
    x1 = (xa > xb) ? xb : xa;
    x2 = (xa > xb) ? xa : xb;
    y1 = (ya > yb) ? yb : ya;
    y2 = (ya > yb) ? ya : yb;
    in_clip = !(x2 < c_l || x1 > c_r || y2 < c_t || y1 > c_b);
    if (x1 < c_l) x1 = c_l;
    if (x2 > c_r) x2 = c_r;
    if (y1 < c_t) y1 = c_t;
    if (y2 > c_b) y2 = c_b;
  end

  // one span held back so the final one can carry the last flag
  logic        pend_v_q;
  logic [59:0] pend_q;
  logic [6:0]  cnt_q;
  logic        strobe_q, valid_q, last_q;
  logic [59:0] out_q;
  logic [1:0]  ost_q;
  logic        take;

  assign take = cmd_i.emit && in_clip && (cnt_q < 7'(OUT_CAP));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      if (cmd_i.load) begin
        pend_v_q <= 1'b0;
        cnt_q    <= '0;
      end else if (take) begin
        strobe_q <= pend_v_q;
        pend_v_q <= 1'b1;
        cnt_q    <= cnt_q + 7'd1;
      end else if (cmd_i.finish) begin
        strobe_q <= 1'b1;
        pend_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      pend_q  <= {x1[14:0], x2[14:0], y1[14:0], y2[14:0]};
      out_q   <= pend_q;
      valid_q <= 1'b1;
      last_q  <= 1'b0;
      ost_q   <= ST_OK;
    end else if (cmd_i.finish) begin
      out_q   <= pend_v_q ? pend_q : '0;
      valid_q <= pend_v_q;
      last_q  <= 1'b1;
      ost_q   <= pend_v_q ? ST_OK : st_q;
    end
  end

  assign span_strobe_o  = strobe_q;
  assign span_valid_o   = valid_q;
  assign span_x_first_o = out_q[59:45];
  assign span_x_last_o  = out_q[44:30];
  assign span_y_first_o = out_q[29:15];
  assign span_y_last_o  = out_q[14:0];
  assign status_o       = ost_q;
  assign last_span_o    = last_q;

endmodule

`default_nettype wire

// ----- hdl/filled_ellipse_span_generator_unit.sv -----
// a rejected or single-span request skips the walk; a filled ellipse runs walk steps
//   of four serial divisions each, all by the larger radius
// throughput: one request at a time; the next start is taken once busy drops
// results leave on span_strobe_o for one cycle each; the receiver cannot stall
// reset: asynchronous, active low; clip registers go to 0, 0, 320, 240
`timescale 1ns / 1ps
`default_nettype none

module filled_ellipse_span_generator_unit import fesg_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write port
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [14:0]        cfg_data_i,
  // request
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] center_x_i,
  input  wire logic signed [15:0] center_y_i,
  input  wire logic signed [15:0] radius_x_i,
  input  wire logic signed [15:0] radius_y_i,
  // spans
  output logic                    span_strobe_o,
  output logic                    span_valid_o,
  output logic [14:0]             span_x_first_o,
  output logic [14:0]             span_x_last_o,
  output logic [14:0]             span_y_first_o,
  output logic [14:0]             span_y_last_o,
  output logic [1:0]              status_o,
  output logic                    last_span_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer: checks, walk steps, span emission order
  fesg_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // clip registers, walk state, divider, span clipping and output stage
  fesg_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .center_x_i     (center_x_i),
    .center_y_i     (center_y_i),
    .radius_x_i     (radius_x_i),
    .radius_y_i     (radius_y_i),
    .span_strobe_o  (span_strobe_o),
    .span_valid_o   (span_valid_o),
    .span_x_first_o (span_x_first_o),
    .span_x_last_o  (span_x_last_o),
    .span_y_first_o (span_y_first_o),
    .span_y_last_o  (span_y_last_o),
    .status_o       (status_o),
    .last_span_o    (last_span_o)
  );

endmodule

`default_nettype wire
